// File: hdl/dig_pkg.sv
// Shared constants and types for the depth/infrared to grey mapper.
package dig_pkg;

    localparam int TONE_ENTRIES_DEF = 256;

    localparam int SAMPLE_W   = 16;
    localparam int MM_W       = 13;
    localparam int RECIP_W    = 25;
    localparam int GAIN_W     = 16;
    localparam int TIDX_W     = 8;
    localparam int GREY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int PROD_A_W   = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_NEAR_MM     = 3'd1,
        CFG_FAR_MM      = 3'd2,
        CFG_DEPTH_RECIP = 3'd3,
        CFG_CLIP_EN     = 3'd4,
        CFG_IR_GAIN     = 3'd5
    } t_cfg_idx;

    localparam logic OP_PIXEL    = 1'b0;
    localparam logic OP_TABLE_WR = 1'b1;

    localparam logic MODE_DEPTH = 1'b0;
    localparam logic MODE_IR    = 1'b1;

    localparam logic              RST_MODE  = MODE_DEPTH;
    localparam logic [MM_W-1:0]   RST_NEAR  = 13'd500;
    localparam logic [MM_W-1:0]   RST_FAR   = 13'd4500;
    localparam logic [RECIP_W-1:0] RST_RECIP = 25'd4194;
    localparam logic              RST_CLIP  = 1'b1;
    localparam logic [GAIN_W-1:0] RST_GAIN  = 16'd4096;

    localparam logic [RECIP_W-1:0] ONE_Q24  = 25'h100_0000;
    localparam logic [RECIP_W-1:0] HALF_Q24 = 25'h080_0000;
    localparam logic [28:0]        IR_FULL  = 29'd268431360;
    localparam int                 IR_DIV   = 65535;

    typedef struct packed {
        logic              op;
        logic              sv;
        logic              black;
        logic [TIDX_W-1:0] tidx;
        logic [GREY_W-1:0] tval;
    } t_ctl;

endpackage

// File: hdl/dig_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/depth_ir_to_grey_mapper.sv
// Top level: depth/infrared sample to grey mapper with loadable tone table.
// Seven register stages lie between input transfer and grey result.
// One item per cycle unless stalled; a table write uses a slot, gives no result.
// Stall from the output ripples back through the stage valid bits to o_stall.
// Synchronous active-low reset clears stage valids and loads register defaults;
// tone table contents are undefined until written.
module depth_ir_to_grey_mapper #(
    parameter int TONE_ENTRIES = dig_pkg::TONE_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [dig_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dig_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_opcode,
    input  logic [dig_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_sample_valid,
    input  logic [dig_pkg::TIDX_W-1:0]       i_table_index,
    input  logic [dig_pkg::GREY_W-1:0]       i_table_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [dig_pkg::GREY_W-1:0]       o_grey
);

    import dig_pkg::*;

    localparam int IDX_W = $clog2(TONE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TONE_ENTRIES - 1);
    localparam int T_W   = SAMPLE_W + RECIP_W;
    localparam int P_W   = SAMPLE_W + GAIN_W;
    localparam int PW    = PROD_A_W + IDX_W;
    localparam int YW    = PW - 11;
    localparam int QW    = YW - 15;
    localparam int TXW   = ((TIDX_W > IDX_W) ? TIDX_W : IDX_W) + 1;
    localparam int NSTG  = 7;

    // configuration registers
    logic               r_mode;
    logic [MM_W-1:0]    r_near;
    logic [MM_W-1:0]    r_far;
    logic [RECIP_W-1:0] r_recip;
    logic               r_clip;
    logic [GAIN_W-1:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_near  <= RST_NEAR;
            r_far   <= RST_FAR;
            r_recip <= RST_RECIP;
            r_clip  <= RST_CLIP;
            r_gain  <= RST_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:        r_mode  <= i_cfg_data[0];
                CFG_NEAR_MM:     r_near  <= i_cfg_data[MM_W-1:0];
                CFG_FAR_MM:      r_far   <= i_cfg_data[MM_W-1:0];
                CFG_DEPTH_RECIP: r_recip <= i_cfg_data[RECIP_W-1:0];
                CFG_CLIP_EN:     r_clip  <= i_cfg_data[0];
                CFG_IR_GAIN:     r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] rdy;

    t_ctl r0_ctl, r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_vld[0] = i_valid;
        for (int k = 1; k < NSTG - 1; k++) begin
            n_vld[k] = r_vld[k-1];
        end
        n_vld[NSTG-1] = r_vld[NSTG-2] && (r5_ctl.op == OP_PIXEL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // stage 0: window tests and offset from near edge
    logic [MM_W:0]       n0_near_p1;
    logic [MM_W:0]       n0_fe;
    logic                n0_black;
    logic                n0_gt;
    logic [SAMPLE_W-1:0] n0_diff;
    t_ctl                n0_ctl;

    logic [SAMPLE_W-1:0] r0_sample;
    logic                r0_gt;
    logic [SAMPLE_W-1:0] r0_diff;

    always_comb begin
        n0_near_p1 = {1'b0, r_near} + (MM_W+1)'(1);
        n0_fe      = ({1'b0, r_far} < n0_near_p1) ? n0_near_p1 : {1'b0, r_far};
        n0_black   = (r_mode == MODE_DEPTH) &&
                     (!i_sample_valid || (i_sample == '0) ||
                      (r_clip && ((i_sample < SAMPLE_W'(r_near)) ||
                                  (i_sample > SAMPLE_W'(n0_fe)))));
        n0_gt      = i_sample > SAMPLE_W'(r_near);
        n0_diff    = i_sample - SAMPLE_W'(r_near);
        n0_ctl.op    = i_opcode;
        n0_ctl.sv    = i_sample_valid;
        n0_ctl.black = n0_black;
        n0_ctl.tidx  = i_table_index;
        n0_ctl.tval  = i_table_value;
    end

    // stage 1: depth and infrared products
    logic [T_W-1:0] r1_t;
    logic [P_W-1:0] r1_p;
    logic           r1_gt;

    // stage 2: saturate and invert
    logic [RECIP_W-1:0]  n2_tsat;
    logic [RECIP_W-1:0]  r2_v;
    logic                r2_full;
    logic [PROD_A_W-1:0] r2_p;

    always_comb begin
        if (!r1_gt) begin
            n2_tsat = '0;
        end else if (r1_t > T_W'(ONE_Q24)) begin
            n2_tsat = ONE_Q24;
        end else begin
            n2_tsat = r1_t[RECIP_W-1:0];
        end
    end

    // stage 3: scale by last table index
    logic [PROD_A_W-1:0] n3_a;
    logic [PW-1:0]       r3_prod;
    logic                r3_full;

    assign n3_a = (r_mode == MODE_IR) ? r2_p : PROD_A_W'(r2_v);

    // stage 4: round depth index, divide infrared term by 2^13 * 65535
    logic [PW:0]    n4_dsum;
    logic [PW+1:0]  n4_x;
    logic [YW-1:0]  n4_y;
    logic [YW:0]    n4_ysum;
    logic [IDX_W-1:0] r4_didx;
    logic [YW-1:0]  r4_y;
    logic [QW-1:0]  r4_q1;
    logic           r4_full;

    always_comb begin
        n4_dsum = (PW+1)'(r3_prod) + (PW+1)'(HALF_Q24);
        n4_x    = ((PW+2)'(r3_prod) << 1) + (PW+2)'(IR_FULL);
        n4_y    = n4_x[PW+1:13];
        n4_ysum = (YW+1)'(n4_y) + (YW+1)'(n4_y >> 16);
    end

    // stage 5: quotient correction, index select, table address
    logic [YW-1:0]    n5_r;
    logic [IDX_W-1:0] n5_q;
    logic [IDX_W-1:0] n5_idx;
    logic [TXW-1:0]   n5_wext;
    logic [IDX_W-1:0] r5_idx;
    logic [IDX_W-1:0] r5_waddr;
    logic             r5_wok;

    always_comb begin
        n5_r    = r4_y + YW'(r4_q1) - (YW'(r4_q1) << 16);
        n5_q    = r4_q1[IDX_W-1:0] + IDX_W'(n5_r >= YW'(IR_DIV));
        n5_wext = TXW'(r4_ctl.tidx);
        if (r_mode == MODE_DEPTH) begin
            n5_idx = r4_didx;
        end else if (!r4_ctl.sv) begin
            n5_idx = '0;
        end else if (r4_full) begin
            n5_idx = LAST;
        end else begin
            n5_idx = n5_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_ctl    <= n0_ctl;
            r0_sample <= i_sample;
            r0_gt     <= n0_gt;
            r0_diff   <= n0_diff;
        end
        if (rdy[1]) begin
            r1_ctl <= r0_ctl;
            r1_gt  <= r0_gt;
            r1_t   <= T_W'(r0_diff) * T_W'(r_recip);
            r1_p   <= P_W'(r0_sample) * P_W'(r_gain);
        end
        if (rdy[2]) begin
            r2_ctl  <= r1_ctl;
            r2_v    <= ONE_Q24 - n2_tsat;
            r2_full <= r1_p >= P_W'(IR_FULL);
            r2_p    <= r1_p[PROD_A_W-1:0];
        end
        if (rdy[3]) begin
            r3_ctl  <= r2_ctl;
            r3_full <= r2_full;
            r3_prod <= PW'(n3_a) * PW'(LAST);
        end
        if (rdy[4]) begin
            r4_ctl  <= r3_ctl;
            r4_full <= r3_full;
            r4_didx <= n4_dsum[24 +: IDX_W];
            r4_y    <= n4_y;
            r4_q1   <= n4_ysum[YW:16];
        end
        if (rdy[5]) begin
            r5_ctl   <= r4_ctl;
            r5_idx   <= n5_idx;
            r5_waddr <= n5_wext[IDX_W-1:0];
            r5_wok   <= n5_wext < TXW'(TONE_ENTRIES);
        end
    end

    // stage 6: tone table access
    logic              ram_we;
    logic [GREY_W-1:0] ram_rdata;
    logic              r6_black;

    assign ram_we = r_vld[NSTG-2] && (r5_ctl.op == OP_TABLE_WR) && r5_wok && rdy[NSTG-1];

    dig_ram #(
        .WIDTH (GREY_W),
        .DEPTH (TONE_ENTRIES)
    ) u_tone_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r5_waddr),
        .i_wdata (r5_ctl.tval),
        .i_re    (rdy[NSTG-1]),
        .i_raddr (r5_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[NSTG-1]) begin
            r6_black <= r5_ctl.black;
        end
    end

    assign o_grey = r6_black ? '0 : ram_rdata;

endmodule

// File: hdl/dig_chk.sv
// Port-level checker for the grey mapper, bound to the top level.
module dig_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_grey
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grey))
        else $error("output transfer dropped or changed under stall");

    a_stall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> i_stall && o_valid)
        else $error("input stalled without a stalled result at the output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid ##1 !o_valid)
        else $error("result shown too soon after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind depth_ir_to_grey_mapper dig_chk u_dig_chk (.*);
